// ===== hw/rtl/tlik_pkg.sv =====
package tlik_pkg;

    // Fixed-point and pipeline sizing
    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int POS_W         = 20;
    localparam int LEN_W         = 18;
    localparam int ELB_W         = 18;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 40;

    // Angle accumulator holds 32 fractional bits
    localparam int ACC_W    = 36;
    localparam int ANG_W    = ACC_W - (32 - FRAC_BITS);
    localparam int CORD_W   = 40;
    localparam int CORD_LAT = CORDIC_STAGES + 2;

    // Cosine quotient and square root widths
    localparam int QUO_W   = FRAC_BITS + 1;
    localparam int C_W     = QUO_W + 1;
    localparam int PROD_W  = 2 * POS_W;
    localparam int SQ_W    = 2 * LEN_W;
    localparam int DEN_W   = SQ_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int V_W     = 2 * FRAC_BITS + 1;
    localparam int CAND_W  = 2 * QUO_W + 1;
    localparam int L2S_W   = LEN_W + QUO_W;
    localparam int L2C_W   = LEN_W + C_W + 1;

    localparam logic [QUO_W-1:0] ONE_Q    = QUO_W'(1) << FRAC_BITS;
    localparam logic [V_W-1:0]   ONE_SQ_Q = V_W'(1) << (2 * FRAC_BITS);

    localparam logic [LEN_W-1:0] LINK_RESET = LEN_W'(19661);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LINK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LINK = CFG_IDX_W'(1);

    localparam logic signed [ACC_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
    localparam longint PI_Q32    = 64'sd13493037704;
    localparam longint ROUND_Q32 = 64'sd1 <<< (31 - FRAC_BITS);
    localparam longint ELBOW_MAX = (PI_Q32 + ROUND_Q32) >>> (32 - FRAC_BITS);

    // Side information that travels with each item
    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
        logic                    neg;
        logic                    unreach;
        logic signed [C_W-1:0]   c;
    } side_t;

    // round(atan(2^-i) * 2^32)
    function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
        logic signed [ACC_W-1:0] v;
        unique case (i)
            0:  v = 36'sd3373259426;
            1:  v = 36'sd1991351318;
            2:  v = 36'sd1052175346;
            3:  v = 36'sd534100635;
            4:  v = 36'sd268086748;
            5:  v = 36'sd134174063;
            6:  v = 36'sd67103403;
            7:  v = 36'sd33553749;
            8:  v = 36'sd16777131;
            9:  v = 36'sd8388597;
            10: v = 36'sd4194303;
            11: v = 36'sd2097152;
            12: v = 36'sd1048576;
            13: v = 36'sd524288;
            14: v = 36'sd262144;
            15: v = 36'sd131072;
            16: v = 36'sd65536;
            17: v = 36'sd32768;
            18: v = 36'sd16384;
            19: v = 36'sd8192;
            20: v = 36'sd4096;
            21: v = 36'sd2048;
            22: v = 36'sd1024;
            23: v = 36'sd512;
            24: v = 36'sd256;
            25: v = 36'sd128;
            26: v = 36'sd64;
            27: v = 36'sd32;
            28: v = 36'sd16;
            29: v = 36'sd8;
            30: v = 36'sd4;
            31: v = 36'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tlik_cordic.sv =====
module tlik_cordic (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [tlik_pkg::CORD_W-1:0]   y_in,
    input  logic signed [tlik_pkg::CORD_W-1:0]   x_in,
    output logic signed [tlik_pkg::ANG_W-1:0]    angle
);
    import tlik_pkg::*;

    logic signed [CORD_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CORD_W-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [ACC_W-1:0]  a_reg [0:CORDIC_STAGES];
    logic                     zero_reg [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0]  angle_reg;
    logic signed [ACC_W-1:0]  rnd;

    // Move the vector into the right half plane.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    a_reg[0] <= HALF_PI_Q32;
                end
                else
                begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    a_reg[0] <= -HALF_PI_Q32;
                end
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                a_reg[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [CORD_W-1:0] dx;
        logic signed [CORD_W-1:0] dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    a_reg[i+1] <= a_reg[i] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    a_reg[i+1] <= a_reg[i] - atan_entry(i);
                end
            end
        end
    end

    // Round the accumulated angle to the output precision.
    assign rnd = a_reg[CORDIC_STAGES] + ACC_W'(ROUND_Q32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[CORDIC_STAGES])
                angle_reg <= '0;
            else
                angle_reg <= rnd[ACC_W-1:ACC_W-ANG_W];
        end
    end

    assign angle = angle_reg;

endmodule

// ===== hw/rtl/two_link_inverse_kinematics.sv =====
// Two-link planar inverse kinematics.
// Input stream s_axis: one target point (x, z) per transaction, signed metres
// with 16 fractional bits. Output stream m_axis: shoulder and elbow angles in
// radians with 16 fractional bits, plus an unreachable flag in tuser that is
// set when the target lies out of reach and the elbow cosine was clamped.
// The user must write the link lengths through the cfg port only while the
// block is idle; the block itself does not enforce this. While the output is
// not stalled, the pipeline takes one point every cycle: the cosine divider
// and the square root resolve one result bit per stage, and the three atan2
// units do one micro-rotation per stage.
// All stages advance together whenever the output register is empty or is
// being read; while it is full and the receiver holds m_axis_tready low,
// s_axis_tready drops and every stage holds its contents, so nothing is lost or repeated.
// Reset clears all valid bits and sets both link lengths to 19661 (0.3 m).
module two_link_inverse_kinematics (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tlik_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // target_x, target_z
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tlik_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // shoulder_angle, elbow_angle
    output logic [0:0]                          m_axis_tuser,   // unreachable
    input  logic                                cfg_wr_en,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlik_pkg::LEN_W-1:0]          cfg_data
);
    import tlik_pkg::*;

    logic adv;

    logic [LEN_W-1:0] upper_link_length_reg;
    logic [LEN_W-1:0] lower_link_length_reg;

    side_t p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [PROD_W-1:0] xx_reg, zz_reg;
    logic [SQ_W-1:0]          l1sq_reg, l2sq_reg, l12_reg;
    logic [MAG_W-1:0]         sum_p_reg;
    logic [DEN_W-1:0]         sum_l_reg, den2_reg, den3_reg;
    logic [MAG_W-1:0]         mag_reg;

    side_t            div_side [0:QUO_W];
    logic [DEN_W-1:0] div_rem  [0:QUO_W];
    logic [DEN_W-1:0] div_den  [0:QUO_W];
    logic [QUO_W-1:0] div_q    [0:QUO_W];

    side_t            c_side_reg, csq_side_reg;
    logic [V_W-1:0]   csq_reg;
    logic [QUO_W-1:0] cmag;
    logic signed [C_W-1:0] c_next;
    logic signed [2*C_W-1:0] csq_full;

    side_t            sq_side [0:QUO_W];
    logic [V_W-1:0]   sq_rem  [0:QUO_W];
    logic [QUO_W-1:0] sq_r    [0:QUO_W];

    side_t                    m_side_reg;
    logic [QUO_W-1:0]         s_reg;
    logic [L2S_W-1:0]         l2s_reg;
    logic signed [L2C_W-1:0]  l2c_reg;

    logic signed [CORD_W-1:0] elb_y, elb_x, tgt_y, tgt_x, tri_y, tri_x;
    logic signed [ANG_W-1:0]  elb_ang, tgt_ang, tri_ang;
    side_t                    cs_side [0:CORD_LAT];

    logic signed [ANG_W:0]    diff;
    logic                     m_valid_reg;
    logic signed [ANG_W-1:0]  shoulder_reg;
    logic [ELB_W-1:0]         elbow_reg;
    logic                     unreach_reg;

    // The whole pipeline moves when the output register can take a result.
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Link length registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_link_length_reg <= LINK_RESET;
            lower_link_length_reg <= LINK_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_UPPER_LINK)
                upper_link_length_reg <= cfg_data;
            else if (cfg_index == CFG_LOWER_LINK)
                lower_link_length_reg <= cfg_data;
        end
    end

    // Input capture, squares and products, then numerator and denominator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
        end
        else if (adv)
        begin
            p0_reg <= '{valid:   s_axis_tvalid,
                        x:       s_axis_tdata[POS_W-1:0],
                        z:       s_axis_tdata[2*POS_W-1:POS_W],
                        neg:     1'b0,
                        unreach: 1'b0,
                        c:       '0};
            p1_reg <= p0_reg;
            p2_reg <= p1_reg;
            p3_reg <= '{valid:   p2_reg.valid,
                        x:       p2_reg.x,
                        z:       p2_reg.z,
                        neg:     sum_p_reg < MAG_W'(sum_l_reg),
                        unreach: p2_reg.unreach,
                        c:       p2_reg.c};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg    <= p0_reg.x * p0_reg.x;
            zz_reg    <= p0_reg.z * p0_reg.z;
            l1sq_reg  <= upper_link_length_reg * upper_link_length_reg;
            l2sq_reg  <= lower_link_length_reg * lower_link_length_reg;
            l12_reg   <= upper_link_length_reg * lower_link_length_reg;
            sum_p_reg <= $unsigned(xx_reg) + $unsigned(zz_reg);
            sum_l_reg <= DEN_W'(l1sq_reg) + DEN_W'(l2sq_reg);
            den2_reg  <= {l12_reg, 1'b0};
            den3_reg  <= den2_reg;
            if (sum_p_reg < MAG_W'(sum_l_reg))
                mag_reg <= MAG_W'(sum_l_reg) - sum_p_reg;
            else
                mag_reg <= sum_p_reg - MAG_W'(sum_l_reg);
        end
    end

    // Clamp check and divider setup.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_side[0] <= '0;
        else if (adv)
        begin
            div_side[0] <= '{valid:   p3_reg.valid,
                             x:       p3_reg.x,
                             z:       p3_reg.z,
                             neg:     p3_reg.neg,
                             unreach: (den3_reg == '0) || (mag_reg > MAG_W'(den3_reg)),
                             c:       p3_reg.c};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_rem[0] <= mag_reg[DEN_W-1:0];
            div_den[0] <= den3_reg;
            div_q[0]   <= '0;
        end
    end

    // Restoring divider: one quotient bit per stage.
    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_div
        logic [DEN_W:0] trial;
        logic           ge;
        assign trial = (j == 1) ? {1'b0, div_rem[j-1]} : {div_rem[j-1], 1'b0};
        assign ge    = trial >= {1'b0, div_den[j-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_side[j] <= '0;
            else if (adv)
                div_side[j] <= div_side[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem[j] <= ge ? DEN_W'(trial - {1'b0, div_den[j-1]}) : trial[DEN_W-1:0];
                div_den[j] <= div_den[j-1];
                div_q[j]   <= {div_q[j-1][QUO_W-2:0], ge};
            end
        end
    end

    // Signed cosine, its square, and the radicand 1 - c*c.
    assign cmag     = div_side[QUO_W].unreach ? ONE_Q : div_q[QUO_W];
    assign c_next   = div_side[QUO_W].neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    assign csq_full = c_side_reg.c * c_side_reg.c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_side_reg   <= '0;
            csq_side_reg <= '0;
            sq_side[0]   <= '0;
        end
        else if (adv)
        begin
            c_side_reg   <= '{valid:   div_side[QUO_W].valid,
                              x:       div_side[QUO_W].x,
                              z:       div_side[QUO_W].z,
                              neg:     div_side[QUO_W].neg,
                              unreach: div_side[QUO_W].unreach,
                              c:       c_next};
            csq_side_reg <= c_side_reg;
            sq_side[0]   <= csq_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            csq_reg   <= csq_full[V_W-1:0];
            sq_rem[0] <= ONE_SQ_Q - csq_reg;
            sq_r[0]   <= '0;
        end
    end

    // Digit-by-digit square root: one result bit per stage.
    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_sqrt
        localparam int K = QUO_W - j;
        logic [CAND_W-1:0] cand;
        logic              fits;
        assign cand = (CAND_W'(sq_r[j-1]) << (K + 1)) + (CAND_W'(1) << (2 * K));
        assign fits = cand <= CAND_W'(sq_rem[j-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_side[j] <= '0;
            else if (adv)
                sq_side[j] <= sq_side[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (fits)
                begin
                    sq_rem[j] <= V_W'(CAND_W'(sq_rem[j-1]) - cand);
                    sq_r[j]   <= sq_r[j-1] | (QUO_W'(1) << K);
                end
                else
                begin
                    sq_rem[j] <= sq_rem[j-1];
                    sq_r[j]   <= sq_r[j-1];
                end
            end
        end
    end

    // Second link terms l2*s and l2*c.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_side_reg <= '0;
        else if (adv)
            m_side_reg <= sq_side[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg   <= sq_r[QUO_W];
            l2s_reg <= lower_link_length_reg * sq_r[QUO_W];
            l2c_reg <= $signed({1'b0, lower_link_length_reg}) * sq_side[QUO_W].c;
        end
    end

    // Vector inputs of the three atan2 units.
    assign elb_y = CORD_W'(s_reg);
    assign elb_x = CORD_W'(m_side_reg.c);
    assign tgt_y = CORD_W'(m_side_reg.x);
    assign tgt_x = -CORD_W'(m_side_reg.z);
    assign tri_y = CORD_W'(l2s_reg);
    assign tri_x = $signed(CORD_W'({upper_link_length_reg, FRAC_BITS'(0)})) + CORD_W'(l2c_reg);

    tlik_cordic u_elbow (
        .clk   (clk),
        .en    (adv),
        .y_in  (elb_y),
        .x_in  (elb_x),
        .angle (elb_ang)
    );

    tlik_cordic u_target (
        .clk   (clk),
        .en    (adv),
        .y_in  (tgt_y),
        .x_in  (tgt_x),
        .angle (tgt_ang)
    );

    tlik_cordic u_triangle (
        .clk   (clk),
        .en    (adv),
        .y_in  (tri_y),
        .x_in  (tri_x),
        .angle (tri_ang)
    );

    // Valid and flag follow the atan2 units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cs_side[0] <= '0;
        else if (adv)
            cs_side[0] <= m_side_reg;
    end

    for (genvar j = 1; j <= CORD_LAT - 1; j++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cs_side[j] <= '0;
            else if (adv)
                cs_side[j] <= cs_side[j-1];
        end
    end

    assign cs_side[CORD_LAT] = cs_side[CORD_LAT-1];

    // Output register: shoulder difference with saturation, elbow clamp.
    assign diff = (ANG_W + 1)'(tgt_ang) - (ANG_W + 1)'(tri_ang);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= cs_side[CORD_LAT].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unreach_reg <= cs_side[CORD_LAT].unreach;
            if (diff > (ANG_W + 1)'((1 << (ANG_W - 1)) - 1))
                shoulder_reg <= ANG_W'((1 << (ANG_W - 1)) - 1);
            else if (diff < -(ANG_W + 1)'(1 << (ANG_W - 1)))
                shoulder_reg <= ANG_W'(1 << (ANG_W - 1));
            else
                shoulder_reg <= diff[ANG_W-1:0];
            if (elb_ang < 0)
                elbow_reg <= '0;
            else if (elb_ang > ANG_W'(ELBOW_MAX))
                elbow_reg <= ELB_W'(ELBOW_MAX);
            else
                elbow_reg <= elb_ang[ELB_W-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({elbow_reg, shoulder_reg});
    assign m_axis_tuser  = unreach_reg;

endmodule
